@@ sv/plfr_pkg.sv @@
package plfr_pkg;

    localparam int LIGHTS_DEF = 8;
    localparam int LIGHTS_MAX = 64;
    // light_index is 3 bits, so at most eight lights are reported per frame
    localparam int REPORT_MAX = 8;

    // configuration register indexes
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_STEP_SIZE = 2'd1;
    localparam logic [1:0] REG_MAX_LEVEL = 2'd2;
    localparam logic [1:0] REG_MIN_LEVEL = 2'd3;

    // mode codes; codes above MODE_BREATHE_DN behave as idle
    localparam logic [2:0] MODE_IDLE       = 3'd0;
    localparam logic [2:0] MODE_FADE_IN    = 3'd1;
    localparam logic [2:0] MODE_FADE_OUT   = 3'd2;
    localparam logic [2:0] MODE_BREATHE_UP = 3'd3;
    localparam logic [2:0] MODE_BREATHE_DN = 3'd4;

    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef struct packed {
        logic [7:0] level;
        t_dir       dir;
    } t_light;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] step_size;
        logic [7:0] max_level;
        logic [7:0] min_level;
    } t_cfg;

endpackage

@@ sv/plfr_cell.sv @@
// One stage of the light ring: holds a light's level and direction and
// takes its neighbor's value whenever the ring advances.
module plfr_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  plfr_pkg::t_light i_light,
    output plfr_pkg::t_light o_light
);
    import plfr_pkg::*;

    t_light r_light;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= '{level: 8'd0, dir: DIR_HOLD};
        end else if (i_shift) begin
            r_light <= i_light;
        end
    end

    assign o_light = r_light;

endmodule

@@ sv/plfr_step.sv @@
// Ramp update for one light: clamp, then hold or reverse at the limit.
module plfr_step (
    input  plfr_pkg::t_cfg   i_cfg,
    input  logic             i_load,
    input  plfr_pkg::t_light i_light,
    output plfr_pkg::t_light o_light
);
    import plfr_pkg::*;

    logic [7:0] w_step;
    logic [8:0] w_sum;
    logic       w_breathe;
    t_dir       w_dir;
    t_dir       w_start;

    assign w_step    = (i_cfg.step_size == 8'd0) ? 8'd1 : i_cfg.step_size;
    assign w_sum     = {1'b0, i_light.level} + {1'b0, w_step};
    assign w_breathe = (i_cfg.mode == MODE_BREATHE_UP) || (i_cfg.mode == MODE_BREATHE_DN);

    always_comb begin
        if ((i_cfg.mode == MODE_FADE_IN) || (i_cfg.mode == MODE_BREATHE_UP)) begin
            w_start = DIR_UP;
        end else if ((i_cfg.mode == MODE_FADE_OUT) || (i_cfg.mode == MODE_BREATHE_DN)) begin
            w_start = DIR_DOWN;
        end else begin
            w_start = DIR_HOLD;
        end
    end

    assign w_dir = i_load ? w_start : i_light.dir;

    always_comb begin
        o_light = '{level: i_light.level, dir: w_dir};
        unique case (w_dir)
            DIR_UP: begin
                if (w_sum > {1'b0, i_cfg.max_level}) begin
                    o_light.level = i_cfg.max_level;
                end else begin
                    o_light.level = w_sum[7:0];
                end
                if (o_light.level >= i_cfg.max_level) begin
                    if (i_cfg.mode == MODE_FADE_IN) begin
                        o_light.dir = DIR_HOLD;
                    end else if (w_breathe) begin
                        o_light.dir = DIR_DOWN;
                    end
                end
            end
            DIR_DOWN: begin
                if ((w_step > i_light.level) ||
                    ((i_light.level - w_step) < i_cfg.min_level)) begin
                    o_light.level = i_cfg.min_level;
                end else begin
                    o_light.level = i_light.level - w_step;
                end
                if (o_light.level <= i_cfg.min_level) begin
                    if (i_cfg.mode == MODE_FADE_OUT) begin
                        o_light.dir = DIR_HOLD;
                    end else if (w_breathe) begin
                        o_light.dir = DIR_UP;
                    end
                end
            end
            default: begin
                // hold: level unchanged, direction stays hold
            end
        endcase
    end

endmodule

@@ sv/per_light_fade_ramp.sv @@
// Per-light fade ramp.
// Slave stream (i_s_*): one request per frame tick; tdata bit 0 = restart,
// which reloads every light's direction from the mode before stepping.
// Master stream (o_m_*): one result per reported light, lights 0..Reported-1 in order,
// tlast on the final reported light of the frame.
// Config channel (i_cfg_*): index 0 mode, 1 step_size, 2 max_level,
// 3 min_level; o_cfg_ready is always high. Write only while idle.
// Lights sit in a ring of cells; a single update unit at the head steps the
// head light and feeds it back into the tail, one light per cycle unless the
// master side stalls the ring; each reported light's result is registered
// as it is stepped. o_s_tready is low for the whole pass, so a new tick is
// taken only after the last light has been stepped.
// A stalled master side freezes the ring (lights beyond the eighth are
// stepped without a result and never wait). Reset zeros all levels and
// directions and restores the register defaults; the first tick after reset
// loads directions from the mode as a restart does.
module per_light_fade_ramp #(
    parameter int LIGHTS = plfr_pkg::LIGHTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: tdata[0] restart, tdata[7:1] zero
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    // master stream: tdata[2:0] light_index, [10:3] brightness,
    // [12:11] ramp_dir, [15:13] zero; tlast = last_light
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import plfr_pkg::*;

    localparam int IdxW     = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;
    localparam int CmpW     = IdxW + 4;
    localparam int Reported = (LIGHTS < REPORT_MAX) ? LIGHTS : REPORT_MAX;

    t_cfg            r_cfg;
    logic            r_busy;
    logic            r_load;
    logic            r_init;
    logic [IdxW-1:0] r_idx;
    logic            r_out_valid;
    logic [15:0]     r_out_data;
    logic            r_out_last;

    t_light          w_ring [LIGHTS];
    t_light          w_stepped;
    logic            w_accept;
    logic            w_reported;
    logic            w_adv;
    logic            w_last_light;
    logic            w_last_rep;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mode: MODE_IDLE, step_size: 8'd1, max_level: 8'd254,
                       min_level: 8'd0};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:      r_cfg.mode      <= i_cfg_data[2:0];
                REG_STEP_SIZE: r_cfg.step_size <= i_cfg_data;
                REG_MAX_LEVEL: r_cfg.max_level <= i_cfg_data;
                REG_MIN_LEVEL: r_cfg.min_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- tick sequencing ----------------
    assign o_s_tready   = !r_busy;
    assign w_accept     = i_s_tvalid && !r_busy;
    assign w_reported   = CmpW'(r_idx) < CmpW'(Reported);
    assign w_last_light = r_idx == IdxW'(LIGHTS - 1);
    assign w_last_rep   = CmpW'(r_idx) == CmpW'(Reported - 1);
    // ring moves unless a reported light finds the output register still full
    assign w_adv        = r_busy && (!w_reported || !r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_load <= 1'b0;
            r_init <= 1'b0;
            r_idx  <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_load <= i_s_tdata[0] || !r_init;
            r_init <= 1'b1;
            r_idx  <= '0;
        end else if (w_adv) begin
            if (w_last_light) begin
                r_busy <= 1'b0;
                r_load <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // ---------------- light ring ----------------
    plfr_step u_step (
        .i_cfg   (r_cfg),
        .i_load  (r_load),
        .i_light (w_ring[0]),
        .o_light (w_stepped)
    );

    for (genvar k = 0; k < LIGHTS; k++) begin : g_cell
        t_light w_in;
        if (k == LIGHTS - 1) begin : g_tail
            assign w_in = w_stepped;
        end else begin : g_mid
            assign w_in = w_ring[k+1];
        end
        plfr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_adv),
            .i_light (w_in),
            .o_light (w_ring[k])
        );
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_reported) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_reported) begin
            r_out_data <= {3'd0, w_stepped.dir, w_stepped.level, 3'(r_idx)};
            r_out_last <= w_last_rep;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // ---------------- checks ----------------
    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_idx == '0)
        else $error("light counter not at zero while idle");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy && r_idx == '0)
        else $error("accepted tick did not start a ring pass");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load |-> r_busy)
        else $error("direction load pending outside a pass");

    a_end_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_last_light) |=> !r_busy && o_s_tready)
        else $error("pass did not finish after last light");

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plfr_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_CYCLES = 5;
    // RTL default; every light below REPORT_MAX gets one result per frame
    localparam int NUM_LIGHTS  = LIGHTS_DEF;
    localparam int NUM_REPORT  = (NUM_LIGHTS < REPORT_MAX) ? NUM_LIGHTS : REPORT_MAX;
    // mode codes with no package name; the block treats them as idle
    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    // time for the ring to finish its pass after the last report drains
    localparam int IDLE_SETTLE = NUM_LIGHTS + 4;
    localparam int END_DRAIN   = 2 * NUM_LIGHTS + 8;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_TICKS  = 205;
    localparam int LIMIT_CYCLES = 400_000;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'd0;   // [0] restart, [7:1] zero
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;            // [2:0] light_index, [10:3] brightness,
                                       // [12:11] ramp_dir, [15:13] zero
    logic        o_m_tlast;            // last_light
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [7:0]  i_cfg_data  = 8'd0;

    per_light_fade_ramp #(
        .LIGHTS(NUM_LIGHTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Ramp model: own copy of the light state and the registers
    // ------------------------------------------------------------------
    typedef struct {
        logic [2:0] idx;
        logic [7:0] lvl;
        t_dir       dir;
        logic       last;
    } t_light_report;

    t_light_report expected_levels[$];

    logic [7:0] model_lvl [NUM_LIGHTS];
    t_dir       model_dir [NUM_LIGHTS];
    logic       model_started = 1'b0;
    t_cfg       ramp_cfg = '{mode: MODE_IDLE, step_size: 8'd1, max_level: 8'd254,
                             min_level: 8'd0};

    int errors = 0;

    initial begin
        for (int i = 0; i < NUM_LIGHTS; i++) begin
            model_lvl[i] = 8'd0;
            model_dir[i] = DIR_HOLD;
        end
    end

    // One frame tick: optional direction reload, step every light, queue the
    // reported levels. A typed row overrides level/dir of every report (all
    // lights share one history, so one value covers them all).
    task automatic step_ramps(input logic restart, input logic typed,
                              input logic [7:0] typed_lvl, input t_dir typed_dir);
        int            stp;
        int            lv;
        logic          breathe;
        t_dir          load_dir;
        t_light_report rep;
        stp = (ramp_cfg.step_size == 8'd0) ? 1 : int'(ramp_cfg.step_size);
        breathe = (ramp_cfg.mode == MODE_BREATHE_UP) || (ramp_cfg.mode == MODE_BREATHE_DN);
        case (ramp_cfg.mode)
            MODE_FADE_IN, MODE_BREATHE_UP: load_dir = DIR_UP;
            MODE_FADE_OUT, MODE_BREATHE_DN: load_dir = DIR_DOWN;
            default: load_dir = DIR_HOLD;
        endcase
        if (restart || !model_started) begin
            for (int i = 0; i < NUM_LIGHTS; i++) model_dir[i] = load_dir;
            model_started = 1'b1;
        end
        for (int i = 0; i < NUM_LIGHTS; i++) begin
            lv = int'(model_lvl[i]);
            if (model_dir[i] == DIR_UP) begin
                if (lv + stp > int'(ramp_cfg.max_level)) lv = int'(ramp_cfg.max_level);
                else lv = lv + stp;
                if (lv >= int'(ramp_cfg.max_level)) begin
                    if (ramp_cfg.mode == MODE_FADE_IN) model_dir[i] = DIR_HOLD;
                    else if (breathe) model_dir[i] = DIR_DOWN;
                end
            end else if (model_dir[i] == DIR_DOWN) begin
                // clamp also raises a light that sits below min_level
                if (lv - stp < int'(ramp_cfg.min_level)) lv = int'(ramp_cfg.min_level);
                else lv = lv - stp;
                if (lv <= int'(ramp_cfg.min_level)) begin
                    if (ramp_cfg.mode == MODE_FADE_OUT) model_dir[i] = DIR_HOLD;
                    else if (breathe) model_dir[i] = DIR_UP;
                end
            end
            model_lvl[i] = lv[7:0];
        end
        for (int i = 0; i < NUM_REPORT; i++) begin
            rep.idx  = i[2:0];
            rep.lvl  = typed ? typed_lvl : model_lvl[i];
            rep.dir  = typed ? typed_dir : model_dir[i];
            rep.last = (i == NUM_REPORT - 1);
            expected_levels.push_back(rep);
        end
    endtask

    // ------------------------------------------------------------------
    // Request side: bursts of random length, random gaps between them.
    // Valid stays high across back-to-back requests; it is only lowered
    // where a gap or an idle wait starts.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned ticks_sent = 0;

    task automatic send_tick(input logic restart, input logic typed,
                             input logic [7:0] typed_lvl, input t_dir typed_dir);
        int unsigned gap;
        i_cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, restart};
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        ticks_sent++;
        step_ramps(restart, typed, typed_lvl, typed_dir);
    endtask

    // Register write; valid is left high so writes can go back to back.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MODE:      ramp_cfg.mode      = data[2:0];
            REG_STEP_SIZE: ramp_cfg.step_size = data;
            REG_MAX_LEVEL: ramp_cfg.max_level = data;
            REG_MIN_LEVEL: ramp_cfg.min_level = data;
            default: ;
        endcase
    endtask

    // Registers may only change with the ring empty: drain every pending
    // light report, then let the ring go around once more.
    task automatic wait_idle();
        i_s_tvalid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall style changes every so often; once, a long hold-off
    // lets the block fill up and push back on the request side.
    // ------------------------------------------------------------------
    typedef enum int {RX_FREE, RX_COIN, RX_LIGHT, RX_THIRD} t_rx_style;

    t_rx_style   rx_style = RX_FREE;
    int unsigned style_left = 0;
    int unsigned hold_left = 0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (style_left == 0) begin
            rx_style   = t_rx_style'($urandom_range(0, 3));
            style_left = $urandom_range(20, 120);
        end else begin
            style_left--;
        end
        if (long_hold_req && !long_hold_done) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_style)
                RX_FREE:  i_m_tready <= 1'b1;
                RX_COIN:  i_m_tready <= $urandom_range(0, 1);
                RX_LIGHT: i_m_tready <= ($urandom_range(0, 3) != 0);
                default:  i_m_tready <= (style_left % 3 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted light report against the oldest one
    // queued by the model
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_light_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_levels.size() == 0) begin
                $error("light report with none pending: tdata=%h tlast=%b",
                       o_m_tdata, o_m_tlast);
                errors++;
            end else begin
                want = expected_levels.pop_front();
                if (o_m_tdata[2:0] !== want.idx) begin
                    $error("light_index: expected %0d, got %0d", want.idx, o_m_tdata[2:0]);
                    errors++;
                end
                if (o_m_tdata[10:3] !== want.lvl) begin
                    $error("brightness: expected %0d, got %0d", want.lvl, o_m_tdata[10:3]);
                    errors++;
                end
                if (o_m_tdata[12:11] !== want.dir) begin
                    $error("ramp_dir: expected %0d, got %0d", want.dir, o_m_tdata[12:11]);
                    errors++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last_light: expected %0d, got %0d", want.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL per_light_fade_ramp");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed plan: register writes and ticks. Typed rows carry the level
    // and direction that every light must show; the others use the model.
    // ------------------------------------------------------------------
    typedef struct {
        logic       is_write;
        logic [1:0] idx;
        logic [7:0] data;
        logic       restart;
        logic       typed;
        logic [7:0] lvl;
        t_dir       dir;
    } t_plan_row;

    localparam int PLAN_ROWS = 43;

    t_plan_row plan [PLAN_ROWS] = '{
        // reset defaults, idle: nothing moves
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b1, 8'd0, DIR_HOLD},
        // fade in with the widest step up to full scale, then hold there
        '{1'b1, REG_MODE, {5'd0, MODE_FADE_IN}, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_STEP_SIZE, 8'd255, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_MAX_LEVEL, 8'd255, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b1, 1'b1, 8'd255, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b1, 8'd255, DIR_HOLD},
        // fade out all the way to zero in one step
        '{1'b1, REG_MODE, {5'd0, MODE_FADE_OUT}, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b1, 1'b1, 8'd0, DIR_HOLD},
        // zero step acts as one; breathe up and reverse at max
        '{1'b1, REG_STEP_SIZE, 8'd0, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_MAX_LEVEL, 8'd3, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_MODE, {5'd0, MODE_BREATHE_UP}, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b1, 1'b1, 8'd1, DIR_UP},
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b1, 8'd2, DIR_UP},
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b1, 8'd3, DIR_DOWN},
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b1, 8'd2, DIR_DOWN},
        // breathe down, reverse at min
        '{1'b1, REG_MODE, {5'd0, MODE_BREATHE_DN}, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b1, 1'b1, 8'd1, DIR_DOWN},
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b1, 8'd0, DIR_UP},
        // unnamed mode codes load hold
        '{1'b1, REG_MODE, {5'd0, MODE_SPARE_5}, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b1, 1'b1, 8'd0, DIR_HOLD},
        '{1'b1, REG_MODE, {5'd0, MODE_SPARE_7}, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b1, 8'd0, DIR_HOLD},
        // inverted clamps; mode change without restart keeps rising;
        // then a falling light below min is raised to min
        '{1'b1, REG_STEP_SIZE, 8'd10, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_MAX_LEVEL, 8'd100, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_MIN_LEVEL, 8'd200, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_MODE, {5'd0, MODE_FADE_IN}, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b1, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_MODE, {5'd0, MODE_BREATHE_DN}, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b1, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        // level above max gets pulled down; idle without restart stays
        // falling pinned at min
        '{1'b1, REG_MIN_LEVEL, 8'd0, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_MAX_LEVEL, 8'd50, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_STEP_SIZE, 8'd100, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_MODE, {5'd0, MODE_BREATHE_UP}, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b1, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_MODE, {5'd0, MODE_IDLE}, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        // max of zero: fade in clamps straight to zero and holds
        '{1'b1, REG_MODE, {5'd0, MODE_FADE_IN}, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b1, REG_MAX_LEVEL, 8'd0, 1'b0, 1'b0, 8'd0, DIR_HOLD},
        '{1'b0, REG_MODE, 8'd0, 1'b1, 1'b1, 8'd0, DIR_HOLD}
    };

    // random register value, extremes weighted in
    function automatic logic [7:0] pick_level(input logic low_bias);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'd0;
        if (roll == 1) return 8'd255;
        return low_bias ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255));
    endfunction

    initial begin
        int unsigned phase_len;
        logic [2:0]  mode_pick;
        logic [7:0]  step_pick;
        logic        prev_was_tick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan; any write after a tick waits for the ring to empty
        prev_was_tick = 1'b1;
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].is_write) begin
                if (prev_was_tick) wait_idle();
                write_reg(plan[r].idx, plan[r].data);
                prev_was_tick = 1'b0;
            end else begin
                send_tick(plan[r].restart, plan[r].typed, plan[r].lvl, plan[r].dir);
                prev_was_tick = 1'b1;
            end
        end

        // random phases: new settings, then a run of ticks; the first tick of
        // most phases restarts so the ramps reach every direction
        ticks_sent = 0;
        long_hold_req = 1'b1;
        while (ticks_sent < RAND_TICKS) begin
            wait_idle();
            if ($urandom_range(0, 4) != 0) begin
                mode_pick = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                        : 3'($urandom_range(1, 4));
                write_reg(REG_MODE, {5'd0, mode_pick});
            end
            if ($urandom_range(0, 1) != 0) begin
                case ($urandom_range(0, 4))
                    0: step_pick = 8'd0;
                    1: step_pick = 8'd255;
                    2: step_pick = 8'($urandom_range(0, 255));
                    default: step_pick = 8'($urandom_range(1, 16));
                endcase
                write_reg(REG_STEP_SIZE, step_pick);
            end
            if ($urandom_range(0, 1) != 0) write_reg(REG_MAX_LEVEL, pick_level(1'b0));
            if ($urandom_range(0, 1) != 0) write_reg(REG_MIN_LEVEL, pick_level(1'b1));
            phase_len = $urandom_range(4, 24);
            for (int t = 0; t < phase_len; t++) begin
                if (t == 0) send_tick(($urandom_range(0, 3) != 0), 1'b0, 8'd0, DIR_HOLD);
                else send_tick(($urandom_range(0, 11) == 0), 1'b0, 8'd0, DIR_HOLD);
            end
        end

        wait_idle();
        repeat (END_DRAIN) @(posedge i_clk);
        if (errors == 0 && expected_levels.size() == 0) begin
            $display("PASS per_light_fade_ramp");
        end else begin
            $display("FAIL per_light_fade_ramp");
        end
        $finish;
    end

endmodule
